### rtl/remp_pkg.sv
// shared types, constants and helpers for the ramped encoder move profile
// no dependencies; the other files that use it refer to this package by scoped names

package remp_pkg;

   // widths of the count arithmetic
   localparam int COUNT_WIDTH = 24;
   localparam int FIELD_WIDTH = 24;
   localparam int WIDE_WIDTH  = ((COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH) + 2;

   // configuration port geometry
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // speed limits in percent
   localparam logic signed [7:0] SPEED_MAX = 8'sd100;
   localparam logic signed [7:0] SPEED_MIN = -8'sd100;

   // register reset values
   localparam logic [6:0]  RAMP_STEP_RESET     = 7'd10;
   localparam logic [15:0] RAMP_INTERVAL_RESET = 16'd200;
   localparam logic [6:0]  MIN_SPEED_RESET     = 7'd10;
   localparam logic [15:0] DECEL_MARGIN_RESET  = 16'd150;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_RAMP_STEP     = 2'd0,
      REG_RAMP_INTERVAL = 2'd1,
      REG_MIN_SPEED     = 2'd2,
      REG_DECEL_MARGIN  = 2'd3
   } reg_index_type;

   // item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // move phases
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_RUN   = 3'd1,
      PH_DECEL = 3'd2,
      PH_REV   = 3'd3
   } phase_type;

   typedef struct packed {
      logic [6:0]  ramp_step;
      logic [15:0] ramp_interval;
      logic [6:0]  min_speed;
      logic [15:0] decel_margin;
   } cfg_type;

   typedef struct packed {
      logic                           kind;
      logic signed [7:0]              move_speed;
      logic signed [FIELD_WIDTH-1:0]  target_counts;
      logic                           ramp_enable;
      logic                           brake_at_end;
      logic signed [FIELD_WIDTH-1:0]  encoder_count;
   } req_type;

   typedef struct packed {
      logic signed [7:0] drive_speed;
      logic              brake_on;
      logic              encoder_clear;
      logic              move_done;
      logic              busy_res;
   } rsp_type;

   // saturate a wide signed value to the count range
   function automatic logic signed [COUNT_WIDTH-1:0] sat_count(
      input logic signed [WIDE_WIDTH-1:0] v);
      logic signed [WIDE_WIDTH-1:0] hi;
      logic signed [WIDE_WIDTH-1:0] lo;
      logic signed [COUNT_WIDTH-1:0] r;
      hi = {{(WIDE_WIDTH-COUNT_WIDTH+1){1'b0}}, {(COUNT_WIDTH-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         r = hi[COUNT_WIDTH-1:0];
      end else if (v < lo) begin
         r = lo[COUNT_WIDTH-1:0];
      end else begin
         r = v[COUNT_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/remp_req_if.sv
// request channel: move start and tick words with valid/ready handshake
// field widths come from remp_pkg

interface remp_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   kind;
   logic signed [7:0]                      move_speed;
   logic signed [remp_pkg::FIELD_WIDTH-1:0] target_counts;
   logic                                   ramp_enable;
   logic                                   brake_at_end;
   logic signed [remp_pkg::FIELD_WIDTH-1:0] encoder_count;

   modport source (
      output valid, kind, move_speed, target_counts, ramp_enable, brake_at_end,
             encoder_count,
      input  ready
   );
   modport sink (
      input  valid, kind, move_speed, target_counts, ramp_enable, brake_at_end,
             encoder_count,
      output ready
   );
endinterface

### rtl/remp_rsp_if.sv
// response channel: drive speed and move status words with valid/ready handshake
// no package dependencies

interface remp_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] drive_speed;
   logic              brake_on;
   logic              encoder_clear;
   logic              move_done;
   logic              busy_res;

   modport source (
      output valid, drive_speed, brake_on, encoder_clear, move_done, busy_res,
      input  ready
   );
   modport sink (
      input  valid, drive_speed, brake_on, encoder_clear, move_done, busy_res,
      output ready
   );
endinterface

### rtl/remp_csr.sv
// apb-style configuration registers for the move profile
// depends on remp_pkg for the register indexes and cfg_type

module remp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [remp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [remp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [remp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output remp_pkg::cfg_type                   cfg
);

   remp_pkg::cfg_type     cfg_ff;
   remp_pkg::cfg_type     cfg_in;
   remp_pkg::reg_index_type index;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign index      = remp_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            remp_pkg::REG_RAMP_STEP:     cfg_in.ramp_step     = csr_pwdata[6:0];
            remp_pkg::REG_RAMP_INTERVAL: cfg_in.ramp_interval = csr_pwdata[15:0];
            remp_pkg::REG_MIN_SPEED:     cfg_in.min_speed     = csr_pwdata[6:0];
            remp_pkg::REG_DECEL_MARGIN:  cfg_in.decel_margin  = csr_pwdata[15:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step     <= remp_pkg::RAMP_STEP_RESET;
         cfg_ff.ramp_interval <= remp_pkg::RAMP_INTERVAL_RESET;
         cfg_ff.min_speed     <= remp_pkg::MIN_SPEED_RESET;
         cfg_ff.decel_margin  <= remp_pkg::DECEL_MARGIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         remp_pkg::REG_RAMP_STEP:     csr_prdata = {25'd0, cfg_ff.ramp_step};
         remp_pkg::REG_RAMP_INTERVAL: csr_prdata = {16'd0, cfg_ff.ramp_interval};
         remp_pkg::REG_MIN_SPEED:     csr_prdata = {25'd0, cfg_ff.min_speed};
         remp_pkg::REG_DECEL_MARGIN:  csr_prdata = {16'd0, cfg_ff.decel_margin};
         default:                     csr_prdata = '0;
      endcase
   end

endmodule

### rtl/remp_core.sv
// move profile state machine: one start or tick word per fire, result out
// depends on remp_pkg for phases, payload types and count saturation

module remp_core (
   input  logic              clock,
   input  logic              reset,
   input  remp_pkg::cfg_type cfg,
   input  logic              fire,
   input  remp_pkg::req_type item,
   output remp_pkg::rsp_type result
);

   localparam int CW = remp_pkg::COUNT_WIDTH;
   localparam int WW = remp_pkg::WIDE_WIDTH;

   remp_pkg::phase_type           phase_ff, phase_in;
   logic signed [7:0]             setpoint_ff, setpoint_in;
   logic signed [7:0]             goal_speed_ff, goal_speed_in;
   logic signed [CW-1:0]          goal_counts_ff, goal_counts_in;
   logic signed [CW-1:0]          brake_offset_ff, brake_offset_in;
   logic [15:0]                   timer_ff, timer_in;
   logic                          ramp_flag_ff, ramp_flag_in;
   logic                          final_brake_ff, final_brake_in;

   logic signed [7:0]             spd;
   logic signed [WW-1:0]          tgt_w;
   logic signed [WW-1:0]          enc_w;
   logic signed [WW-1:0]          goal_w;
   logic signed [WW-1:0]          brake_point_w;
   logic signed [9:0]             sp_sum;
   logic signed [9:0]             sp_diff;
   logic signed [9:0]             min_w;
   logic [15:0]                   timer_inc;
   logic                          move_end;

   assign tgt_w     = WW'(item.target_counts);
   assign enc_w     = WW'(item.encoder_count);
   assign min_w     = {3'b000, cfg.min_speed};
   assign timer_inc = (timer_ff != 16'hFFFF) ? timer_ff + 16'd1 : timer_ff;
   assign goal_w    = WW'(goal_counts_ff);
   assign sp_sum    = 10'(setpoint_ff) + {3'b000, cfg.ramp_step};
   assign sp_diff   = 10'(setpoint_ff) - {3'b000, cfg.ramp_step};

   // requested speed clamped to the percent range
   always_comb begin
      if (item.move_speed > remp_pkg::SPEED_MAX) begin
         spd = remp_pkg::SPEED_MAX;
      end else if (item.move_speed < remp_pkg::SPEED_MIN) begin
         spd = remp_pkg::SPEED_MIN;
      end else begin
         spd = item.move_speed;
      end
   end

   // next state and result
   always_comb begin
      phase_in        = phase_ff;
      setpoint_in     = setpoint_ff;
      goal_speed_in   = goal_speed_ff;
      goal_counts_in  = goal_counts_ff;
      brake_offset_in = brake_offset_ff;
      timer_in        = timer_ff;
      ramp_flag_in    = ramp_flag_ff;
      final_brake_in  = final_brake_ff;
      brake_point_w   = goal_w;
      move_end        = 1'b0;
      result          = '0;

      if (item.kind == remp_pkg::KIND_START) begin
         // set up a new move, dropping any running one
         ramp_flag_in    = item.ramp_enable;
         final_brake_in  = item.brake_at_end;
         brake_offset_in = '0;
         timer_in        = '0;
         if (spd > 8'sd0 && item.target_counts > 0) begin
            goal_speed_in  = spd;
            goal_counts_in = remp_pkg::sat_count(tgt_w);
            if (item.ramp_enable) begin
               if ({1'b0, cfg.ramp_step} > remp_pkg::SPEED_MAX) begin
                  setpoint_in = remp_pkg::SPEED_MAX;
               end else begin
                  setpoint_in = {1'b0, cfg.ramp_step};
               end
            end else begin
               setpoint_in = spd;
            end
            phase_in = remp_pkg::PH_RUN;
         end else begin
            goal_speed_in  = (spd > 8'sd0) ? -spd : spd;
            goal_counts_in = remp_pkg::sat_count((item.target_counts > 0) ? -tgt_w : tgt_w);
            setpoint_in    = goal_speed_in;
            phase_in       = remp_pkg::PH_REV;
         end
         result.drive_speed   = setpoint_in;
         result.encoder_clear = 1'b1;
         result.busy_res      = 1'b1;
      end else begin
         timer_in = timer_inc;
         case (phase_ff)
            remp_pkg::PH_RUN: begin
               // ramp up, record braking offset at full speed
               if (setpoint_ff < goal_speed_ff && timer_inc > cfg.ramp_interval) begin
                  if (sp_sum >= 10'(goal_speed_ff)) begin
                     setpoint_in     = goal_speed_ff;
                     brake_offset_in = remp_pkg::sat_count(
                        enc_w - WW'({1'b0, cfg.decel_margin}));
                  end else begin
                     setpoint_in = sp_sum[7:0];
                  end
                  timer_in = '0;
               end
               brake_point_w = goal_w - WW'(brake_offset_in);
               if (enc_w >= brake_point_w) begin
                  if (ramp_flag_ff && enc_w < goal_w) begin
                     phase_in = remp_pkg::PH_DECEL;
                     timer_in = '0;
                  end else begin
                     move_end = 1'b1;
                  end
               end
            end
            remp_pkg::PH_DECEL: begin
               // step down towards the floor speed
               if (10'(goal_speed_ff) > min_w && timer_inc > cfg.ramp_interval) begin
                  if (sp_diff < min_w) begin
                     setpoint_in = min_w[7:0];
                  end else begin
                     setpoint_in = sp_diff[7:0];
                  end
                  timer_in = '0;
               end
               if (enc_w >= goal_w) begin
                  move_end = 1'b1;
               end
            end
            remp_pkg::PH_REV: begin
               if (enc_w < goal_w) begin
                  move_end = 1'b1;
               end
            end
            default: begin
               phase_in = remp_pkg::PH_IDLE;
            end
         endcase

         if (move_end) begin
            phase_in           = remp_pkg::PH_IDLE;
            result.brake_on    = final_brake_ff;
            result.move_done   = 1'b1;
         end else if (phase_ff == remp_pkg::PH_IDLE) begin
            result.brake_on    = final_brake_ff;
         end else begin
            result.drive_speed = setpoint_in;
            result.busy_res    = 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= remp_pkg::PH_IDLE;
         setpoint_ff     <= '0;
         goal_speed_ff   <= '0;
         goal_counts_ff  <= '0;
         brake_offset_ff <= '0;
         timer_ff        <= '0;
         ramp_flag_ff    <= 1'b0;
         final_brake_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         setpoint_ff     <= setpoint_in;
         goal_speed_ff   <= goal_speed_in;
         goal_counts_ff  <= goal_counts_in;
         brake_offset_ff <= brake_offset_in;
         timer_ff        <= timer_in;
         ramp_flag_ff    <= ramp_flag_in;
         final_brake_ff  <= final_brake_in;
      end
   end

endmodule

### rtl/ramped_encoder_move_profile_top.sv
// top level of the ramped encoder move profile
// depends on remp_pkg, remp_req_if, remp_rsp_if, remp_csr and remp_core
//
//   channel   direction  handshake         payload
//   req_chan  in         valid/ready       kind, speed, target, ramp, brake, encoder
//   rsp_chan  out        valid/ready       drive speed, brake, clear, done, busy
//   csr_*     in/out     apb, pready high  four config registers at 4*i
//
// one word per cycle sustained while the response is not stalled; an accepted word waits
// in the input register, and its result is loaded into the response register to leave.
// the profile state updates once per word, so words chain without bubbles.
// synchronous active-high reset clears state, valids and config registers to defaults.
// a stalled response holds its register; the input register takes a word while it
// is empty, or while the response register is free or drained in the same cycle.

module ramped_encoder_move_profile_top (
   input  logic                                clock,
   input  logic                                reset,
   remp_req_if.sink                            req_chan,
   remp_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [remp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [remp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [remp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   remp_pkg::cfg_type cfg;
   remp_pkg::req_type stage_item_ff;
   logic              stage_valid_ff, stage_valid_in;
   remp_pkg::rsp_type out_item_ff;
   logic              out_valid_ff, out_valid_in;
   remp_pkg::rsp_type step_result;
   logic              out_load;
   logic              advance;
   logic              in_fire;

   remp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   remp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (advance),
      .item   (stage_item_ff),
      .result (step_result)
   );

   // pipeline flow control
   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign advance        = stage_valid_ff && out_load;
   assign req_chan.ready = !stage_valid_ff || out_load;
   assign in_fire        = req_chan.valid && req_chan.ready;

   assign stage_valid_in = in_fire ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
   assign out_valid_in   = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (in_fire) begin
         stage_item_ff.kind          <= req_chan.kind;
         stage_item_ff.move_speed    <= req_chan.move_speed;
         stage_item_ff.target_counts <= req_chan.target_counts;
         stage_item_ff.ramp_enable   <= req_chan.ramp_enable;
         stage_item_ff.brake_at_end  <= req_chan.brake_at_end;
         stage_item_ff.encoder_count <= req_chan.encoder_count;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.drive_speed   = out_item_ff.drive_speed;
   assign rsp_chan.brake_on      = out_item_ff.brake_on;
   assign rsp_chan.encoder_clear = out_item_ff.encoder_clear;
   assign rsp_chan.move_done     = out_item_ff.move_done;
   assign rsp_chan.busy_res      = out_item_ff.busy_res;

endmodule
